// ===== hw/rtl/multichannel_input_debouncer_top_assert.svh =====
// Assertion macros for the debouncer checker file.
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_TOP_ASSERT_SVH

// Check a property on every clock while out of reset.
`define MID_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock.
`define MID_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mid_pkg.sv =====
// Package with constants, codes and types for the multichannel input debouncer.
package mid_pkg;

    localparam int CHANNELS     = 64;
    localparam int NOISE_WINDOW = 100;

    localparam int CHAN_W   = 6;
    localparam int LEVEL_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CNT_W    = 16;
    localparam int TIMER_W  = 7;
    localparam int GROUPS   = 4;
    localparam int GROUP_W  = 2;
    localparam int GBITS    = 16;
    localparam int CHAN_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_AW   = 2;

    localparam logic [LEVEL_W-1:0] LVL_OFF   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_ON    = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_FAULT = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_NOISE_LIMIT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ON_SETTLE   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_OFF_SETTLE  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_SATURATED = 16'hFFFF;

    // Per-channel state word held in the state RAM.
    typedef struct packed {
        logic [LEVEL_W-1:0] last_level;
        logic [LEVEL_W-1:0] filtered;
        logic [CNT_W-1:0]   settle_count;
        logic [TIMER_W-1:0] window_timer;
        logic [CNT_W-1:0]   change_count;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    typedef struct packed {
        logic [CFG_W-1:0] noise_limit;
        logic [CFG_W-1:0] on_settle;
        logic [CFG_W-1:0] off_settle;
    } cfg_t;

    // Result of one channel update.
    typedef struct packed {
        logic               wr_en;
        chan_state_t        state;
        logic [LEVEL_W-1:0] flev;
        logic               noisy;
        logic [GBITS-1:0]   group_word;
    } tick_res_t;

endpackage

// ===== hw/rtl/mid_state_ram.sv =====
// Per-channel state RAM with registered read and valid bits that read as zero.
module mid_state_ram
    import mid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [CHAN_AW-1:0]  rd_addr,
    output chan_state_t         rd_data,
    input  logic                wr_en,
    input  logic [CHAN_AW-1:0]  wr_addr,
    input  chan_state_t         wr_data
);

    chan_state_t             mem [CHANNELS];
    logic [CHANNELS-1:0]     valid_reg;
    chan_state_t             rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A never-written entry reads as the reset state.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/mid_tick_unit.sv =====
// Debounce, settle and noise-window update for one channel sample.
module mid_tick_unit
    import mid_pkg::*;
(
    input  chan_state_t         cur,
    input  logic [LEVEL_W-1:0]  level,
    input  logic [CHAN_W-1:0]   channel,
    input  logic                in_range,
    input  cfg_t                cfg,
    input  logic [GBITS-1:0]    group_in,
    output tick_res_t           res
);

    logic [LEVEL_W-1:0] sample;
    chan_state_t        nxt;
    logic [3:0]         bit_idx;
    logic [GBITS-1:0]   bit_mask;

    always_comb
    begin
        // Reject the unused level code: treat it as a repeat.
        sample = (level > LVL_FAULT) ? cur.last_level : level;
        nxt    = cur;

        if (cur.window_timer < TIMER_W'(NOISE_WINDOW))
        begin
            nxt.window_timer = cur.window_timer + TIMER_W'(1);
        end
        else if (cur.change_count > cfg.noise_limit)
        begin
            nxt.change_count = CNT_SATURATED;
        end
        else
        begin
            nxt.change_count = '0;
            nxt.window_timer = '0;
        end

        if (sample == LVL_FAULT)
        begin
            nxt.filtered   = LVL_FAULT;
            nxt.last_level = LVL_FAULT;
        end
        else
        begin
            if (sample != cur.last_level)
            begin
                nxt.change_count = nxt.change_count + CNT_W'(1);
                nxt.settle_count = (sample == LVL_ON) ? cfg.on_settle : cfg.off_settle;
            end
            else if (cur.settle_count == '0)
            begin
                nxt.filtered = sample;
            end
            else
            begin
                nxt.settle_count = cur.settle_count - CNT_W'(1);
            end
            nxt.last_level = sample;
        end

        bit_idx  = channel[3:0];
        bit_mask = GBITS'(1) << bit_idx;

        res.wr_en = in_range;
        res.state = nxt;
        if (in_range)
        begin
            res.flev       = nxt.filtered;
            res.noisy      = (nxt.change_count > cfg.noise_limit);
            res.group_word = (nxt.filtered == LVL_ON) ? (group_in | bit_mask)
                                                      : (group_in & ~bit_mask);
        end
        else
        begin
            res.flev       = LVL_FAULT;
            res.noisy      = 1'b0;
            res.group_word = group_in;
        end
    end

endmodule

// ===== hw/rtl/multichannel_input_debouncer_top.sv =====
// Top level of the multichannel input debouncer: RAM pipeline, config and stream ports.
// Takes one sample transaction per cycle and returns one result transaction per sample,
// passed through the update stage and the output register. Per-channel state lives in
// a 64-entry RAM with a registered read; the update stage writes back as it hands on its result
// and forwards its write to a sample for the same channel accepted at that edge, so
// back-to-back samples on one channel need no bubble. Reset state comes from per-entry
// valid bits, so there is no clearing pass. Results sit in an output register; the
// input stalls only while that register and the update stage are both full and the
// result side is not ready.
module multichannel_input_debouncer_top
    import mid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // channel[5:0], level[7:6]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_channel[5:0], filtered_level[7:6], noisy[8], group_index[10:9],
    // group_word[26:11], zero fill [31:27]
    output logic [31:0]         m_axis_tdata,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    cfg_t                cfg_reg;
    logic [GBITS-1:0]    bitmap_reg [GROUPS];

    logic                s1_valid_reg;
    logic [CHAN_W-1:0]   s1_chan_reg;
    logic [LEVEL_W-1:0]  s1_level_reg;
    logic                fwd_hit_reg;
    chan_state_t         fwd_data_reg;

    logic                out_valid_reg;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [LEVEL_W-1:0]  out_flev_reg;
    logic                out_noisy_reg;
    logic [GBITS-1:0]    out_word_reg;

    logic                accept;
    logic                out_load;
    logic                s1_fire;
    logic [CHAN_W-1:0]   in_chan;
    logic [LEVEL_W-1:0]  in_level;
    logic                s1_in_range;
    logic [GROUP_W-1:0]  s1_group;
    chan_state_t         ram_rd;
    chan_state_t         cur_state;
    tick_res_t           res;
    logic                wr_en;
    logic [CHAN_AW-1:0]  wr_addr;

    assign in_chan  = s_axis_tdata[CHAN_W-1:0];
    assign in_level = s_axis_tdata[CHAN_W+LEVEL_W-1:CHAN_W];

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_fire       = s1_valid_reg && out_load;

    assign s1_in_range = {1'b0, s1_chan_reg} < (CHAN_W+1)'(CHANNELS);
    assign s1_group    = s1_chan_reg[CHAN_W-1:CHAN_W-GROUP_W];
    assign wr_en       = s1_fire && res.wr_en;
    assign wr_addr     = s1_chan_reg[CHAN_AW-1:0];

    mid_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_chan[CHAN_AW-1:0]),
        .rd_data (ram_rd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (res.state)
    );

    // Take the write-back in place of the stale read on a same-channel overlap.
    assign cur_state = fwd_hit_reg ? fwd_data_reg : ram_rd;

    mid_tick_unit u_tick (
        .cur      (cur_state),
        .level    (s1_level_reg),
        .channel  (s1_chan_reg),
        .in_range (s1_in_range),
        .cfg      (cfg_reg),
        .group_in (bitmap_reg[s1_group]),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_limit <= CFG_W'(10);
            cfg_reg.on_settle   <= CFG_W'(5);
            cfg_reg.off_settle  <= CFG_W'(5);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_NOISE_LIMIT: cfg_reg.noise_limit <= cfg_wdata;
                CFG_ON_SETTLE:   cfg_reg.on_settle   <= cfg_wdata;
                CFG_OFF_SETTLE:  cfg_reg.off_settle  <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                bitmap_reg[g] <= '0;
            end
        end
        else if (wr_en)
        begin
            bitmap_reg[s1_group] <= res.group_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (wr_addr == in_chan[CHAN_AW-1:0]);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_chan_reg  <= in_chan;
            s1_level_reg <= in_level;
            fwd_data_reg <= res.state;
        end
        if (s1_fire)
        begin
            out_chan_reg  <= s1_chan_reg;
            out_flev_reg  <= res.flev;
            out_noisy_reg <= res.noisy;
            out_word_reg  <= res.group_word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_word_reg, out_chan_reg[CHAN_W-1:CHAN_W-GROUP_W],
                            out_noisy_reg, out_flev_reg, out_chan_reg};

endmodule

// ===== hw/rtl/mid_checker.sv =====
// Port-level checker for the multichannel input debouncer, bound to the top level.
`include "multichannel_input_debouncer_top_assert.svh"

module mid_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [31:0]         m_axis_tdata
);

    `MID_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    `MID_ASSERT_CLK(a_flev_code, !m_axis_tvalid || (m_axis_tdata[7:6] != 2'd3), "filtered level out of range")

    `MID_ASSERT_CLK(a_group_idx, !m_axis_tvalid || (m_axis_tdata[10:9] == m_axis_tdata[5:4]), "group index does not match channel")

    `MID_ASSERT_CLK(a_group_bit, !m_axis_tvalid || (m_axis_tdata[32'(11) + 32'(m_axis_tdata[3:0])] == (m_axis_tdata[7:6] == 2'd1)), "group word bit disagrees with filtered level")

endmodule

bind multichannel_input_debouncer_top mid_checker u_mid_checker (.*);

// ===== dv/multichannel_input_debouncer_top_tb.sv =====
// Self-checking testbench for the multichannel input debouncer, predictor included.
module multichannel_input_debouncer_top_tb;
    import mid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [LEVEL_W-1:0] LVL_REJECT = 2'd3;
    localparam logic [CFG_AW-1:0]  CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Packed to match m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [4:0]         pad;
        logic [GBITS-1:0]   group_word;
        logic [GROUP_W-1:0] group_index;
        logic               noisy;
        logic [LEVEL_W-1:0] flev;
        logic [CHAN_W-1:0]  channel;
    } debounce_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;
    logic                cfg_wr_en;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    multichannel_input_debouncer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Predictor state
    logic [LEVEL_W-1:0] ch_last    [CHANNELS];
    logic [LEVEL_W-1:0] ch_filt    [CHANNELS];
    logic [CNT_W-1:0]   ch_settle  [CHANNELS];
    logic [TIMER_W-1:0] ch_window  [CHANNELS];
    logic [CNT_W-1:0]   ch_changes [CHANNELS];
    logic [GBITS-1:0]   on_words   [GROUPS];
    logic [CFG_W-1:0]   noise_limit_q;
    logic [CFG_W-1:0]   on_settle_q;
    logic [CFG_W-1:0]   off_settle_q;

    debounce_result_t pending_results[$];
    int mismatches = 0;
    int sender_mode = 1;
    int sink_mode = 1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void reset_predictor();
        noise_limit_q = 16'd10;
        on_settle_q   = 16'd5;
        off_settle_q  = 16'd5;
        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_last[i]    = LVL_OFF;
            ch_filt[i]    = LVL_OFF;
            ch_settle[i]  = '0;
            ch_window[i]  = '0;
            ch_changes[i] = '0;
        end
        for (int g = 0; g < GROUPS; g++)
            on_words[g] = '0;
    endfunction

    // Advance one channel by one tick and return the result the block should report.
    function automatic debounce_result_t debounce_sample(input logic [CHAN_W-1:0] ch,
                                                         input logic [LEVEL_W-1:0] raw);
        logic [LEVEL_W-1:0] lvl;
        debounce_result_t r;
        // A rejected sample counts as a repeat of the last level.
        lvl = (raw == LVL_REJECT) ? ch_last[ch] : raw;

        if (ch_window[ch] < NOISE_WINDOW)
            ch_window[ch] = ch_window[ch] + 7'd1;
        else if (ch_changes[ch] > noise_limit_q)
            ch_changes[ch] = CNT_SATURATED;
        else
        begin
            ch_changes[ch] = '0;
            ch_window[ch]  = '0;
        end

        if (lvl == LVL_FAULT)
        begin
            ch_filt[ch] = LVL_FAULT;
            ch_last[ch] = LVL_FAULT;
        end
        else
        begin
            if (lvl != ch_last[ch])
            begin
                ch_changes[ch] = ch_changes[ch] + 16'd1;
                ch_settle[ch]  = (lvl == LVL_ON) ? on_settle_q : off_settle_q;
            end
            else if (ch_settle[ch] == '0)
                ch_filt[ch] = lvl;
            else
                ch_settle[ch] = ch_settle[ch] - 16'd1;
            ch_last[ch] = lvl;
        end

        on_words[ch[5:4]][ch[3:0]] = (ch_filt[ch] == LVL_ON);

        r.pad         = '0;
        r.channel     = ch;
        r.flev        = ch_filt[ch];
        r.noisy       = (ch_changes[ch] > noise_limit_q);
        r.group_index = ch[5:4];
        r.group_word  = on_words[ch[5:4]];
        return r;
    endfunction

    function automatic int pick_delay(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42)
            return LVL_OFF;
        else if (r < 84)
            return LVL_ON;
        else
            return LVL_FAULT;
    endfunction

    function automatic logic [CFG_W-1:0] pick_settle();
        if ($urandom_range(0, 9) == 0)
            return CFG_W'($urandom_range(0, 65535));
        return CFG_W'($urandom_range(0, 6));
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = pick_delay(sender_mode);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lvl, ch};
        // Ready seen mid-cycle means the transaction completes at the next edge.
        do
            @(negedge clk);
        while (!s_axis_tready);
        pending_results.push_back(debounce_sample(ch, lvl));
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_NOISE_LIMIT: noise_limit_q = val;
            CFG_ON_SETTLE:   on_settle_q   = val;
            CFG_OFF_SETTLE:  off_settle_q  = val;
            default: ;
        endcase
    endtask

    task automatic test_power_on_defaults();
        send_sample(6'd0, LVL_OFF);
        send_sample(6'd5, LVL_REJECT);
        // Default settle of 5: the seventh on sample is accepted.
        repeat (7) send_sample(6'd63, LVL_ON);
        send_sample(6'd63, LVL_REJECT);
        send_sample(6'd42, LVL_FAULT);
        send_sample(6'd42, LVL_REJECT);
        send_sample(6'd42, LVL_OFF);
        send_sample(6'd48, LVL_ON);
    endtask

    task automatic test_settle_extremes();
        wait_for_results();
        write_reg(CFG_NOISE_LIMIT, 16'd0);
        write_reg(CFG_ON_SETTLE, 16'd0);
        write_reg(CFG_OFF_SETTLE, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_sample(6'd16, LVL_ON);
        send_sample(6'd16, LVL_ON);
        send_sample(6'd16, LVL_OFF);
        send_sample(6'd16, LVL_OFF);
        send_sample(6'd31, LVL_FAULT);
        send_sample(6'd31, LVL_ON);
        send_sample(6'd31, LVL_ON);

        wait_for_results();
        write_reg(CFG_NOISE_LIMIT, 16'd65534);
        write_reg(CFG_ON_SETTLE, 16'hFFFF);
        write_reg(CFG_OFF_SETTLE, 16'hFFFF);
        repeat (3) send_sample(6'd47, LVL_ON);
        repeat (2) send_sample(6'd47, LVL_OFF);
        repeat (2) send_sample(6'd63, LVL_OFF);
    endtask

    // Run full windows: one channel keeps toggling, one settles after a burst of changes.
    task automatic test_noise_window();
        wait_for_results();
        write_reg(CFG_NOISE_LIMIT, 16'd3);
        write_reg(CFG_ON_SETTLE, 16'd1);
        write_reg(CFG_OFF_SETTLE, 16'd1);
        for (int i = 0; i < 120; i++)
        begin
            send_sample(6'd9, (i < 110 && i[0]) ? LVL_ON : LVL_OFF);
            send_sample(6'd10, (i < 8 && i[0]) ? LVL_ON : LVL_OFF);
        end
    endtask

    task automatic test_random_traffic();
        logic [CHAN_W-1:0]  pool     [4];
        logic [LEVEL_W-1:0] target   [4];
        int                 run_left [4];
        int slot;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_for_results();
            case ($urandom_range(0, 3))
                0: write_reg(CFG_NOISE_LIMIT, 16'd0);
                1: write_reg(CFG_NOISE_LIMIT, CFG_W'($urandom_range(1, 20)));
                2: write_reg(CFG_NOISE_LIMIT, CFG_W'($urandom_range(0, 65534)));
                default: write_reg(CFG_NOISE_LIMIT, 16'd65534);
            endcase
            write_reg(CFG_ON_SETTLE, pick_settle());
            write_reg(CFG_OFF_SETTLE, pick_settle());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 65535)));

            // Keep the same channels most phases so their noise windows run out.
            if (phase == 0 || $urandom_range(0, 2) == 0)
                for (int k = 0; k < 4; k++)
                begin
                    pool[k]     = CHAN_W'($urandom_range(0, 63));
                    run_left[k] = 0;
                end

            sender_mode = (phase == 2) ? 0 : 1;
            sink_mode   = (phase == 2) ? 0 : 1;

            for (int n = 0; n < 140; n++)
            begin
                if (n == 70 && phase[0])
                    wait_for_results();
                slot = $urandom_range(0, 3);
                if ($urandom_range(0, 19) == 0)
                    send_sample(CHAN_W'($urandom_range(0, 63)),
                                LEVEL_W'($urandom_range(0, 3)));
                else
                begin
                    if (run_left[slot] == 0)
                    begin
                        target[slot]   = pick_level();
                        run_left[slot] = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                                     : $urandom_range(1, 8);
                    end
                    run_left[slot]--;
                    send_sample(pool[slot],
                                ($urandom_range(0, 24) == 0) ? LVL_REJECT : target[slot]);
                end
            end
        end
        sender_mode = 1;
        sink_mode   = 1;
    endtask

    // Result sink with random backpressure.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = pick_delay(sink_mode);
            end
        end
    end

    always @(negedge clk)
    begin : result_check
        debounce_result_t want;
        debounce_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = debounce_result_t'(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_channel", 16'(want.channel), 16'(got.channel));
                check_field("filtered_level", 16'(want.flev), 16'(got.flev));
                check_field("noisy", 16'(want.noisy), 16'(got.noisy));
                check_field("group_index", 16'(want.group_index), 16'(got.group_index));
                check_field("group_word", want.group_word, got.group_word);
                check_field("zero fill", 16'(want.pad), 16'(got.pad));
            end
        end
    end

    // Abort when no transaction moves on either side for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        reset_predictor();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_settle_extremes();
        test_noise_window();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
